// ===== rtl/tfc_pkg.sv =====
// -----------------------------------------------------------------------------
// tfc_pkg
// Types and constants shared by the token frequency counter modules.
// -----------------------------------------------------------------------------
`default_nettype none
package tfc_pkg;

   localparam logic [7:0]  CHAR_COMMA   = 8'd44;
   localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
   localparam logic [7:0]  CHAR_SPACE   = 8'd32;
   localparam int          LEN_W        = 5;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0]  entry_index;
      logic [15:0] token_count;
      logic        is_new_entry;
      logic        dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;         // request accepted this cycle
      logic start;        // token finished, rewind search index
      logic next;         // advance search index
      logic commit_hit;   // bump count of matched entry
      logic commit_miss;  // insert, or drop when full
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fin;          // current request would finish a token
      logic rsp_busy;     // result register still occupied
      logic used_zero;    // table empty
      logic key_match;    // read entry equals pending token
      logic idx_last;     // read entry is the last one in use
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/token_frequency_counter.sv =====
// -----------------------------------------------------------------------------
// token_frequency_counter
// Splits a byte stream into tokens and counts each distinct token.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one byte per request (valid/stall). Comma and newline end a
//   token, space too when the csr bit split_on_space is set; end_of_input
//   also ends a pending token. Each finished token yields one rsp_* result
//   (entry index, count, new and dropped flags).
//   Ordinary bytes are taken one per cycle outside a search. A finishing
//   byte starts a linear search of the key memory, a registered read then a
//   compare per entry: a hit posts its result when its entry is compared, a
//   miss when the last entry in use is compared, or after the first read on
//   an empty table; no request is taken during the search.
//   The result sits in an output register; while rsp_stall holds it, further
//   ordinary bytes are still taken and only a finishing byte is stalled.
//   The csr port (always ready) writes split_on_space; write it while idle.
//   Reset (synchronous) empties the table, the pending token and the result.
// -----------------------------------------------------------------------------
`default_nettype none
module token_frequency_counter
   import tfc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int KEY_CHARS     = 31
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic       split_ff;
   cmd_type    cmd;
   status_type sts;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         split_ff <= csr_data;
      end
   end

   tfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfc_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_CHARS     (KEY_CHARS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .split_on_space (split_ff),
      .req_data       (req_data),
      .rsp_data       (rsp_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
`default_nettype wire

// ===== rtl/tfc_ctrl.sv =====
// -----------------------------------------------------------------------------
// tfc_ctrl
// Sequencer: accepts bytes and walks the table search for a finished token.
// -----------------------------------------------------------------------------
`default_nettype none
module tfc_ctrl
   import tfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type sts,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // hold a finishing request while the last result is unread
            req_stall = sts.fin & sts.rsp_busy;
            cmd.take  = req_valid & ~req_stall;
            if (cmd.take && sts.fin) begin
               cmd.start = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.used_zero) begin
               cmd.commit_miss = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.key_match) begin
               cmd.commit_hit = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.idx_last) begin
               cmd.commit_miss = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.next = 1'b1;
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // a search never commits a hit and a miss together
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit_hit && cmd.commit_miss))
      else $error("double commit");
   // requests are only taken in idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> state_ff == ST_IDLE)
      else $error("request taken during search");
   // a start is followed by a read cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_READ)
      else $error("search did not start");
`endif

endmodule
`default_nettype wire

// ===== rtl/tfc_dp.sv =====
// -----------------------------------------------------------------------------
// tfc_dp
// Datapath: pending token buffer, key and count memories, result register.
// -----------------------------------------------------------------------------
`default_nettype none
module tfc_dp
   import tfc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int KEY_CHARS     = 31
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    split_on_space,
   input  wire req_type req_data,
   output rsp_type      rsp_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire cmd_type cmd,
   output status_type   sts
);

   localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int UW   = $clog2(TABLE_ENTRIES + 1);
   localparam int CW   = 8 * KEY_CHARS;
   localparam int KW   = CW + LEN_W;

   logic [KW-1:0]    key_mem [TABLE_ENTRIES];
   logic [15:0]      cnt_mem [TABLE_ENTRIES];
   logic [KW-1:0]    key_rd_ff;
   logic [15:0]      cnt_rd_ff;
   logic [CW-1:0]    pbuf_ff;
   logic [LEN_W-1:0] plen_ff;
   logic [IW-1:0]    idx_ff;
   logic [UW-1:0]    used_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             is_sep;
   logic             full;
   logic [15:0]      cnt_inc;

   assign is_sep = (req_data.char_in == CHAR_COMMA) || (req_data.char_in == CHAR_NEWLINE)
                   || (split_on_space && (req_data.char_in == CHAR_SPACE));
   assign full   = (used_ff == UW'(TABLE_ENTRIES));
   assign cnt_inc = (cnt_rd_ff == COUNT_MAX) ? COUNT_MAX : cnt_rd_ff + 16'd1;

   assign sts.fin       = is_sep ? (plen_ff != '0) : req_data.end_of_input;
   assign sts.rsp_busy  = rsp_valid_ff;
   assign sts.used_zero = (used_ff == '0);
   assign sts.key_match = (key_rd_ff == {plen_ff, pbuf_ff});
   assign sts.idx_last  = (UW'(idx_ff) == used_ff - UW'(1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memories: one read port at the search index, one write port
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[idx_ff];
      cnt_rd_ff <= cnt_mem[idx_ff];
      if (cmd.commit_hit) begin
         cnt_mem[idx_ff] <= cnt_inc;
      end
      if (cmd.commit_miss && !full) begin
         key_mem[used_ff[IW-1:0]] <= {plen_ff, pbuf_ff};
         cnt_mem[used_ff[IW-1:0]] <= 16'd1;
      end
   end

   // pending token buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         pbuf_ff <= '0;
         plen_ff <= '0;
      end else if (cmd.commit_hit || cmd.commit_miss) begin
         pbuf_ff <= '0;
         plen_ff <= '0;
      end else if (cmd.take && !is_sep && (32'(plen_ff) < KEY_CHARS)) begin
         pbuf_ff[8*plen_ff +: 8] <= req_data.char_in;
         plen_ff                 <= plen_ff + LEN_W'(1);
      end
   end

   // search index and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         used_ff <= '0;
      end else begin
         if (cmd.start) begin
            idx_ff <= '0;
         end else if (cmd.next) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.commit_miss && !full) begin
            used_ff <= used_ff + UW'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit_hit || cmd.commit_miss) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_hit) begin
         rsp_ff <= '{entry_index: 8'(idx_ff), token_count: cnt_inc,
                     is_new_entry: 1'b0, dropped: 1'b0};
      end else if (cmd.commit_miss && !full) begin
         rsp_ff <= '{entry_index: 8'(used_ff), token_count: 16'd1,
                     is_new_entry: 1'b1, dropped: 1'b0};
      end else if (cmd.commit_miss) begin
         rsp_ff <= '{entry_index: 8'd0, token_count: 16'd0,
                     is_new_entry: 1'b0, dropped: 1'b1};
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TABLE_ENTRIES))
      else $error("fill count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_hit || cmd.commit_miss) |=> plen_ff == '0 && rsp_valid_ff)
      else $error("commit did not clear token or post result");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_miss && !full) |=> used_ff == $past(used_ff) + UW'(1))
      else $error("insert did not advance fill count");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit_hit |-> UW'(idx_ff) < used_ff)
      else $error("hit on unused entry");
`endif

endmodule
`default_nettype wire
